// ===== rtl/core/typed_field_byte_serializer_top_assert.svh =====
// Assertion macros for the typed field byte serializer.
`ifndef TYPED_FIELD_BYTE_SERIALIZER_TOP_ASSERT_SVH
`define TYPED_FIELD_BYTE_SERIALIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tfbs_pkg.sv =====
// Package with the shared types and constants of the typed field byte serializer.
package tfbs_pkg;

    // Field kind codes.
    localparam logic [2:0] OP_BOOL  = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_SHORT = 3'd2;
    localparam logic [2:0] OP_INT   = 3'd3;
    localparam logic [2:0] OP_LONG  = 3'd4;
    localparam logic [2:0] OP_VARINT = 3'd5;
    localparam logic [2:0] OP_POS   = 3'd6;

    // VarInt group mask and continuation bit.
    localparam logic [7:0] VAR_GROUP_MASK = 8'b0111_1111;
    localparam logic [7:0] VAR_CONT_BIT   = 8'b1000_0000;

    // Job queue geometry.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified field: a left-aligned big-endian word with its byte count, or a
    // VarInt value held in the low 32 bits.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        varint;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/tfbs_if.sv =====
// Channel interfaces for the field input and the byte output.
interface tfbs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] value;
    logic signed [25:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [25:0] pos_z;

    modport source (output valid, operation, value, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, operation, value, pos_x, pos_y, pos_z, output ready);
endinterface

interface tfbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/core/tfbs_front.sv =====
// Front end: accepts field items and classifies them into serializer jobs.
module tfbs_front
    import tfbs_pkg::*;
(
    tfbs_in_if.sink  i_in,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_job     o_job
);

    // Accept whenever the queue has room.
    assign i_in.ready = !i_q_stat.full;

    // Build the job word and byte count for each field kind.
    always_comb begin
        o_job  = '0;
        o_push = i_in.valid && !i_q_stat.full;
        case (i_in.operation)
            OP_BOOL: begin
                o_job.word   = {7'd0, (i_in.value != 64'd0), 56'd0};
                o_job.nbytes = 4'd1;
            end
            OP_BYTE: begin
                o_job.word   = {i_in.value[7:0], 56'd0};
                o_job.nbytes = 4'd1;
            end
            OP_SHORT: begin
                o_job.word   = {i_in.value[15:0], 48'd0};
                o_job.nbytes = 4'd2;
            end
            OP_INT: begin
                o_job.word   = {i_in.value[31:0], 32'd0};
                o_job.nbytes = 4'd4;
            end
            OP_LONG: begin
                o_job.word   = i_in.value;
                o_job.nbytes = 4'd8;
            end
            OP_VARINT: begin
                o_job.word   = {32'd0, i_in.value[31:0]};
                o_job.varint = 1'b1;
            end
            OP_POS: begin
                o_job.word   = {i_in.pos_x, i_in.pos_y, i_in.pos_z};
                o_job.nbytes = 4'd8;
            end
            default: begin
                // The unused code is taken but yields no bytes.
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tfbs_queue.sv =====
// Short job queue between the front end and the byte serializer.
module tfbs_queue
    import tfbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tfbs_back.sv =====
// Back end: sends one job out as a run of bytes through an output register.
module tfbs_back
    import tfbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    tfbs_out_if.source o_out
);

    logic        r_busy;
    logic [63:0] r_word;
    logic [3:0]  r_left;
    logic        r_varint;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        step;
    logic [7:0]  n_byte;
    logic        n_last;
    logic [63:0] n_word;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

    // Load a new job when idle, and emit a byte when the output register is free.
    assign o_pop = !r_busy && !i_q_stat.empty;
    assign step  = r_busy && (!r_out_valid || o_out.ready);

    // Next byte, its last flag and the remaining word.
    always_comb begin
        if (r_varint) begin
            n_word = {7'd0, r_word[63:7]};
            n_last = (n_word[31:0] == 32'd0);
            n_byte = (r_word[7:0] & VAR_GROUP_MASK) | (n_last ? 8'd0 : VAR_CONT_BIT);
        end else begin
            n_word = {r_word[55:0], 8'd0};
            n_last = (r_left == 4'd1);
            n_byte = r_word[63:56];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (step && n_last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job and output payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word   <= i_job.word;
            r_left   <= i_job.nbytes;
            r_varint <= i_job.varint;
        end else if (step) begin
            r_word <= n_word;
            r_left <= r_left - 1'b1;
        end
        if (step) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

endmodule

// ===== rtl/core/typed_field_byte_serializer_top.sv =====
// Typed field byte serializer: top level joining front end, job queue and back end.
//
// Usage: each transfer on i_in carries one typed protocol field (boolean, byte,
// short, int, long, VarInt or packed block position). The block sends the field's
// bytes in wire order on o_out, one byte per transfer, with last_byte set on the
// final byte. Code 7 is taken and yields no bytes.
// Path: when the back end is idle, the first byte of a field passes through the job
// queue, the back end's job registers and its output register before it is valid.
// Throughput: the back end loads a job and then sends its 1 to 8 bytes, one per
// cycle unless o_out.ready stalls it; it takes no new job until the last byte is
// in its output register, and that loop sets the sustained rate. The front end
// classifies in the cycle of the transfer and a two-entry job queue lets it keep
// accepting while bytes go out. Reset: i_rst_n is synchronous and active low; it
// empties the queue, drops any field in progress and clears o_out.valid.
// Stall: while the receiver holds o_out.ready low the current byte is held, the
// back end waits, and i_in.ready falls once the queue is full.
`include "typed_field_byte_serializer_top_assert.svh"

module typed_field_byte_serializer_top
    import tfbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfbs_in_if.sink    i_in,
    tfbs_out_if.source o_out
);

    t_job    front_job;
    t_job    q_job;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // Classification of incoming fields.
    tfbs_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    // Job queue.
    tfbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    // Byte serializer.
    tfbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_job),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    // The queue can never report full and empty together.
    `TFBS_ASSERT_NOW(a_q_stat_sane, i_clk, i_rst_n, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty at once")

    // A job is only taken from a queue that holds one.
    `TFBS_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_stat.empty, "pop from empty queue")

    // A pushed job with no pop leaves the queue non-empty.
    `TFBS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && !q_stat.full && !q_pop, !q_stat.empty, "pushed job lost")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the typed field byte serializer: field stimulus, byte prediction and checking.
`timescale 1ns / 1ps

module tb;
    import tfbs_pkg::*;

    // The one code that the package leaves unnamed; it yields no bytes.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_FIELDS = 270;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_CYCLES  = 16;
    localparam int STUCK_LIMIT   = 2000;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [25:0] x;
        logic [11:0] y;
        logic [25:0] z;
        bit          settle;
    } t_field_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_COMB,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    tfbs_in_if  in_ch ();
    tfbs_out_if out_ch ();

    typed_field_byte_serializer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_field_item pending_fields[$];
    t_wire_byte  wire_bytes_q[$];
    t_field_item cur_field;
    int          err_cnt;
    int          burst_left;
    int          gap_left;
    int          settle_wait;
    int          rx_phase;
    t_rx_mode    rx_mode;

    // Clock, and known values on every input from time zero.
    initial begin
        i_clk            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_BOOL;
        in_ch.value      = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        in_ch.pos_z      = '0;
        out_ch.ready     = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        err_cnt++;
    endtask

    task automatic push_wire_byte(input logic [7:0] data, input logic last);
        t_wire_byte b;
        b.data = data;
        b.last = last;
        wire_bytes_q.push_back(b);
    endtask

    // Low nbytes of the word, most significant byte first.
    task automatic push_big_endian(input logic [63:0] word, input int nbytes);
        logic [63:0] shifted;
        for (int i = nbytes - 1; i >= 0; i--) begin
            shifted = word >> (i * 8);
            push_wire_byte(shifted[7:0], i == 0);
        end
    endtask

    // Expected wire bytes of one accepted field.
    task automatic serialize_field(input t_field_item f);
        logic [31:0] v;
        logic [7:0]  grp;
        bit          done;
        case (f.kind)
            OP_BOOL: begin
                push_wire_byte((f.value != '0) ? 8'd1 : 8'd0, 1'b1);
            end
            OP_BYTE: begin
                push_wire_byte(f.value[7:0], 1'b1);
            end
            OP_SHORT: begin
                push_big_endian({48'd0, f.value[15:0]}, 2);
            end
            OP_INT: begin
                push_big_endian({32'd0, f.value[31:0]}, 4);
            end
            OP_LONG: begin
                push_big_endian(f.value, 8);
            end
            OP_VARINT: begin
                // Seven bits per byte, least significant group first.
                v = f.value[31:0];
                done = 1'b0;
                while (!done) begin
                    grp = v[7:0] & VAR_GROUP_MASK;
                    v = v >> 7;
                    if (v != '0) begin
                        push_wire_byte(grp | VAR_CONT_BIT, 1'b0);
                    end else begin
                        push_wire_byte(grp, 1'b1);
                        done = 1'b1;
                    end
                end
            end
            OP_POS: begin
                push_big_endian({f.x, f.y, f.z}, 8);
            end
            default: begin
                // The unused code produces nothing.
            end
        endcase
    endtask

    task automatic add_field(input logic [2:0] kind, input logic [63:0] value,
                             input logic [25:0] x, input logic [11:0] y,
                             input logic [25:0] z, input bit settle);
        t_field_item f;
        f.kind   = kind;
        f.value  = value;
        f.x      = x;
        f.y      = y;
        f.z      = z;
        f.settle = settle;
        pending_fields.push_back(f);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Driver: presents queued fields in bursts, with gaps, and holds a field back
    // until the output has drained where the field asks for it.
    always @(posedge i_clk) begin : field_driver
        logic take;
        logic present;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            take = in_ch.valid && in_ch.ready;
            if (take) begin
                serialize_field(cur_field);
            end
            present = in_ch.valid && !take;
            if (!present && pending_fields.size() != 0) begin
                if (pending_fields[0].settle &&
                    (wire_bytes_q.size() != 0 || settle_wait < SETTLE_CYCLES)) begin
                    settle_wait = (wire_bytes_q.size() != 0) ? 0 : settle_wait + 1;
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    cur_field = pending_fields.pop_front();
                    settle_wait = 0;
                    in_ch.operation <= cur_field.kind;
                    in_ch.value     <= cur_field.value;
                    in_ch.pos_x     <= cur_field.x;
                    in_ch.pos_y     <= cur_field.y;
                    in_ch.pos_z     <= cur_field.z;
                    present = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end
            end
            in_ch.valid <= present;
        end
    end

    // Monitor: checks every byte transfer against the oldest expectation and
    // stalls the output on a pattern that changes every so often.
    always @(posedge i_clk) begin : byte_monitor
        t_wire_byte want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_phase = 0;
            rx_mode = RX_STREAM;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (wire_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                              out_ch.out_byte));
                end else begin
                    want = wire_bytes_q.pop_front();
                    if (out_ch.out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_ch.out_byte, want.data));
                    if (out_ch.last_byte !== want.last)
                        report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                                  out_ch.last_byte, want.last, want.data));
                end
            end
            rx_phase++;
            if (rx_phase % 96 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            if (rx_mode == RX_STREAM)
                out_ch.ready <= 1'b1;
            else if (rx_mode == RX_COIN)
                out_ch.ready <= 1'($urandom_range(0, 1));
            else if (rx_mode == RX_COMB)
                out_ch.ready <= (rx_phase % 4) != 0;
            else
                out_ch.ready <= ($urandom_range(0, 7) == 0);
        end
    end

    // Watchdog: ends the run once no transfer has happened for too long.
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [2:0]  kind;
        logic [63:0] value;
        logic [25:0] x;
        logic [25:0] z;
        logic [11:0] y;
        int          n;
        i_rst_n     = 1'b0;
        err_cnt     = 0;
        burst_left  = 4;
        gap_left    = 0;
        settle_wait = 0;

        // Directed fields: extremes, every kind and each special case.
        add_field(OP_BOOL, 64'd0, '0, '0, '0, 1'b0);
        add_field(OP_BOOL, 64'h8000_0000_0000_0000, '1, '1, '1, 1'b0);
        add_field(OP_BOOL, 64'd1, '0, '0, '0, 1'b0);
        add_field(OP_BYTE, 64'hFFFF_FFFF_FFFF_FF00, '0, '0, '0, 1'b0);
        add_field(OP_BYTE, 64'h0000_0000_0000_00FF, '0, '0, '0, 1'b0);
        add_field(OP_SHORT, 64'hFFFF_FFFF_FFFF_0000, '0, '0, '0, 1'b0);
        add_field(OP_SHORT, 64'h0000_0000_0000_FFFF, '0, '0, '0, 1'b0);
        add_field(OP_INT, 64'hFFFF_FFFF_8000_0001, '0, '0, '0, 1'b0);
        add_field(OP_INT, 64'h0000_0000_FFFF_FFFF, '0, '0, '0, 1'b0);
        add_field(OP_LONG, 64'h0000_0000_0000_0000, '0, '0, '0, 1'b0);
        add_field(OP_LONG, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, 1'b0);
        add_field(OP_LONG, 64'h0123_4567_89AB_CDEF, '0, '0, '0, 1'b0);
        add_field(OP_VARINT, 64'd0, '0, '0, '0, 1'b1);
        add_field(OP_VARINT, 64'd127, '0, '0, '0, 1'b0);
        add_field(OP_VARINT, 64'd128, '0, '0, '0, 1'b0);
        add_field(OP_VARINT, 64'd16384, '0, '0, '0, 1'b0);
        add_field(OP_VARINT, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, 1'b0);
        add_field(OP_VARINT, 64'hABCD_0000_8000_0000, '0, '0, '0, 1'b0);
        add_field(OP_POS, 64'hFFFF_FFFF_FFFF_FFFF, 26'h200_0000, 12'h800, 26'h200_0000, 1'b0);
        add_field(OP_POS, 64'd0, 26'h1FF_FFFF, 12'h7FF, 26'h1FF_FFFF, 1'b0);
        add_field(OP_POS, 64'd0, '1, '1, '1, 1'b0);
        add_field(OP_POS, 64'd0, '0, '0, '0, 1'b0);
        add_field(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, '1, 1'b0);
        add_field(OP_BYTE, 64'h5A, '0, '0, '0, 1'b0);
        add_field(OP_UNUSED, 64'd0, '0, '0, '0, 1'b1);

        // Random fields with full-width values; VarInts spread over every length.
        n = 0;
        while (n < RANDOM_FIELDS) begin
            kind  = 3'($urandom_range(0, 6));
            value = rand_word();
            if ($urandom_range(0, 9) == 0)
                value = ($urandom_range(0, 1) != 0) ? '1 : '0;
            if (kind == OP_VARINT)
                value = {value[63:32], value[31:0] >> $urandom_range(0, 31)};
            x = 26'($urandom);
            y = 12'($urandom_range(0, 4095));
            z = 26'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                x = ($urandom_range(0, 1) != 0) ? 26'h200_0000 : 26'h1FF_FFFF;
                y = ($urandom_range(0, 1) != 0) ? 12'h800 : 12'h7FF;
            end
            add_field(kind, value, x, y, z, (n % 80) == 79);
            n++;
            // Now and then an unused code that must produce nothing.
            if ($urandom_range(0, 19) == 0)
                add_field(OP_UNUSED, rand_word(), x, y, z, 1'b0);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_fields.size() != 0 || in_ch.valid)
            @(negedge i_clk);
        while (wire_bytes_q.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);

        if (wire_bytes_q.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", wire_bytes_q.size()));
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tfbs_pkg.sv
rtl/core/tfbs_if.sv
rtl/core/tfbs_front.sv
rtl/core/tfbs_queue.sv
rtl/core/tfbs_back.sv
rtl/core/typed_field_byte_serializer_top.sv
tb/tb.sv
